// ===== sv/kle_pkg.sv =====
// Package for the keystroke line editor: store size, key codes and the
// command and status structs between controller and datapath.
// No dependencies.
package kle_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int KEY_W    = 8;

  localparam logic [KEY_W-1:0] KEY_LEFT  = 8'd60;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'd62;
  localparam logic [KEY_W-1:0] KEY_BACK  = 8'd45;

  typedef struct packed {
    logic cap_in;
    logic edit;
    logic rd_en;
    logic rd_drain;
    logic move_wr;
    logic out_load;
    logic out_load_empty;
    logic clear_line;
  } kle_cmd_t;

  typedef struct packed {
    logic move_ok;
    logic eol;
    logic total_zero;
    logic last_k;
    logic out_free;
  } kle_stat_t;

endpackage

// ===== sv/kle_ctrl.sv =====
// Controller state machine of the keystroke line editor.
// Depends on kle_pkg; drives the datapath kle_dpath by command signals.
module kle_ctrl import kle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  kle_stat_t stat,
  output kle_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_MWR    = 3'd2;
  localparam logic [2:0] ST_DCHK   = 3'd3;
  localparam logic [2:0] ST_DRD    = 3'd4;
  localparam logic [2:0] ST_DOUT   = 3'd5;
  localparam logic [2:0] ST_DEMPTY = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.move_ok) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_MWR;
        end else begin
          cmd.edit  = 1'b1;
          state_nxt = stat.eol ? ST_DCHK : ST_IDLE;
        end
      end
      ST_MWR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = stat.eol ? ST_DCHK : ST_IDLE;
      end
      ST_DCHK: begin
        state_nxt = stat.total_zero ? ST_DEMPTY : ST_DRD;
      end
      ST_DRD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_drain = 1'b1;
        state_nxt    = ST_DOUT;
      end
      ST_DOUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.last_k) begin
            cmd.clear_line = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_DRD;
          end
        end
      end
      ST_DEMPTY: begin
        if (stat.out_free) begin
          cmd.out_load_empty = 1'b1;
          cmd.clear_line     = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/kle_dpath.sv =====
// Datapath of the keystroke line editor: gap-buffer store, cursor counts,
// drain index and output register. Depends on kle_pkg; commanded by kle_ctrl.
module kle_dpath import kle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [KEY_W-1:0] in_tdata,
  input  logic             in_tlast,
  input  kle_cmd_t         cmd,
  output kle_stat_t        stat,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic [1:0]       out_tuser
);

  logic [KEY_W-1:0] mem [CAPACITY];

  logic [KEY_W-1:0] key_r;
  logic             eol_r;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [CNT_W-1:0] right_r, right_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [KEY_W-1:0] rd_data_r;

  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;
  logic             out_empty_r;
  logic             out_ovf_r;

  logic [SUM_W-1:0]  total;
  logic              full;
  logic              mv_left, mv_right, is_back, is_ins;
  logic [CNT_W-1:0]  lm_addr, mv_addr;
  logic [SUM_W-1:0]  dr_addr;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;
  logic [KEY_W-1:0]  wr_data;

  always_comb begin
    total    = {1'b0, left_r} + {1'b0, right_r};
    full     = (total == SUM_W'(CAPACITY));
    mv_left  = (key_r == KEY_LEFT);
    mv_right = (key_r == KEY_RIGHT);
    is_back  = (key_r == KEY_BACK);
    is_ins   = !mv_left && !mv_right && !is_back;

    lm_addr  = CNT_W'(CAPACITY - 1) - right_r;
    mv_addr  = mv_left ? (left_r - CNT_W'(1)) : (CNT_W'(CAPACITY) - right_r);
    dr_addr  = (k_r < left_r) ? {1'b0, k_r}
                              : ({1'b0, k_r} + (SUM_W'(CAPACITY) - total));
    rd_addr  = cmd.rd_drain ? dr_addr[ADDR_W-1:0] : mv_addr[ADDR_W-1:0];

    wr_en    = (cmd.edit && is_ins && !full) || cmd.move_wr;
    wr_addr  = (cmd.move_wr && mv_left) ? lm_addr[ADDR_W-1:0] : left_r[ADDR_W-1:0];
    wr_data  = cmd.move_wr ? rd_data_r : key_r;
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    ovf_nxt   = ovf_r;
    k_nxt     = k_r;
    if (cmd.clear_line) begin
      left_nxt  = '0;
      right_nxt = '0;
      ovf_nxt   = 1'b0;
      k_nxt     = '0;
    end else if (cmd.edit) begin
      if (is_back && (left_r != '0)) begin
        left_nxt = left_r - CNT_W'(1);
      end else if (is_ins) begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          left_nxt = left_r + CNT_W'(1);
        end
      end
    end else if (cmd.move_wr) begin
      if (mv_left) begin
        left_nxt  = left_r - CNT_W'(1);
        right_nxt = right_r + CNT_W'(1);
      end else begin
        left_nxt  = left_r + CNT_W'(1);
        right_nxt = right_r - CNT_W'(1);
      end
    end else if (cmd.out_load) begin
      k_nxt = k_r + CNT_W'(1);
    end
  end

  always_comb begin
    stat.move_ok    = (mv_left && (left_r != '0)) || (mv_right && (right_r != '0));
    stat.eol        = eol_r;
    stat.total_zero = (total == '0);
    stat.last_k     = (({1'b0, k_r} + SUM_W'(1)) == total);
    stat.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      key_r <= in_tdata;
      eol_r <= in_tlast;
    end
    if (cmd.out_load) begin
      out_char_r  <= rd_data_r;
      out_last_r  <= stat.last_k;
      out_empty_r <= 1'b0;
      out_ovf_r   <= ovf_r;
    end else if (cmd.out_load_empty) begin
      out_char_r  <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
      out_ovf_r   <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      right_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      ovf_r   <= ovf_nxt;
      k_r     <= k_nxt;
      if (cmd.out_load || cmd.out_load_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total <= SUM_W'(CAPACITY))
    else $error("line length exceeds store capacity");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_line |=> (left_r == '0) && (right_r == '0) && !ovf_r && (k_r == '0))
    else $error("line state not cleared after drain");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load || cmd.out_load_empty) |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while held");

  a_move_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |-> $past(cmd.rd_en && !cmd.rd_drain))
    else $error("cursor move write without a preceding read");

endmodule

// ===== sv/keystroke_line_editor.sv =====
// Top level of the keystroke line editor: controller plus datapath.
// Depends on kle_pkg, kle_ctrl and kle_dpath.
//
//   Channel  Direction  Payload
//   in_      slave      tdata = key_code[7:0], tlast = end_of_line
//   out_     master     tdata = out_char[7:0], tlast = last_char,
//                       tuser = {overflowed, line_empty}
//
// Insert, backspace and a blocked cursor move pass the idle and execute states;
// a cursor move adds a write state, since the store is read at its single read
// port and then written. A last keystroke adds a check state, then a read and an
// output state per character, or one empty-line beat, held while out_tready is low.
// Reset is synchronous and empties the line; the store itself is not cleared.
// The final result may wait in the output register while the next keystroke
// is taken.
module keystroke_line_editor import kle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [KEY_W-1:0] in_tdata,   // [7:0] key_code
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_char
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // [0] line_empty, [1] overflowed
);

  kle_cmd_t  cmd;
  kle_stat_t stat;

  kle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kle_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
